FILE: design/centered_moving_average_top_macros.svh
// Assertion macros for the centered moving average block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef CENTERED_MOVING_AVERAGE_TOP_MACROS_SVH
`define CENTERED_MOVING_AVERAGE_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define CMA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define CMA_ASSERT_NEVER(label, clk, rst, expr, msg) \
   `CMA_ASSERT(label, clk, rst, !(expr), msg)

`else

`define CMA_ASSERT(label, clk, rst, prop, msg)

`define CMA_ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

FILE: design/cma_pkg.sv
// Shared constants and controller/datapath interface types for the
// centered moving average block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cma_pkg;

   localparam int MAX_RADIUS_DEF = 31;
   localparam int SAMPLE_W       = 8;
   localparam int RADIUS_W       = 5;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);

   // register index, taken from paddr[CSR_ADDR_W-1:2]
   localparam logic REG_RADIUS = 1'b0;

   typedef struct packed {
      logic capture;
      logic sub_evict;
      logic push;
      logic rd_trim;
      logic sub_trim;
      logic div_start;
      logic flush_init;
      logic flush_step;
      logic load_out;
      logic flush_flag;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic need_evict;
      logic emit_ok;
      logic last;
      logic c_zero;
      logic trim_more;
      logic div_busy;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: design/centered_moving_average_top.sv
// Centered moving average over one record of 8-bit unsigned samples.
// Input request channel req_*: one sample per request, req_tlast marks the
// last sample of a record. Result channel rsp_*: a request gives no mean while
// the window is still filling and one mean once radius+1 samples are in. The
// last request of a record also flushes the means still owed, and rsp_tlast
// marks the final mean of the record. Means lag inputs by radius samples.
// From request to mean: read and subtract of the evicted sample once the
// window is full, store update, the 14-step iterative divide, output load.
// One request is worked on at a time: the next is taken once the block is
// back in idle, after its mean, if one is due, is loaded. Each flushed mean
// takes a divide, plus a read and subtract for each sample trimmed off the
// window top. The output register lets a new request be taken while a result
// waits. A stalled receiver holds the result in the output register; the
// block finishes the next mean, waits to load it and takes no request meanwhile.
// Reset: radius = 1, empty record; no memory clearing pass. Writing radius
// over the APB port drops any partial record.
// Depends on cma_pkg, cma_ctrl, cma_dp, cma_div.
`timescale 1ns / 1ps
`default_nettype none

module centered_moving_average_top #(
   parameter int MAX_RADIUS = cma_pkg::MAX_RADIUS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,   // [7:0] sample
   input  wire logic                            req_tlast,   // last_sample
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [7:0]                           rsp_tdata,   // [7:0] mean_sample
   output logic                                 rsp_tlast,   // last_mean
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [cma_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [cma_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cma_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import cma_pkg::*;

   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic                reg_sel;
   logic                cfg_wr;
   cmd_type             cmd;
   status_type          sts;

   assign reg_sel    = (csr_paddr[CSR_ADDR_W-1:2] == REG_RADIUS);
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && reg_sel;
   assign radius_in  = cfg_wr ? csr_pwdata[RADIUS_W-1:0] : radius_ff;
   assign csr_prdata = reg_sel ? CSR_DATA_W'(radius_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else begin
         radius_ff <= radius_in;
      end
   end

   cma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   cma_dp #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .radius     (radius_ff),
      .cfg_clear  (cfg_wr),
      .cmd        (cmd),
      .sts        (sts),
      .in_sample  (req_tdata),
      .in_last    (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_mean   (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: design/cma_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Used by cma_dp; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cma_div #(
   parameter int DIVIDEND_W = 14,
   parameter int DIVISOR_W  = 6
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       busy,
   output logic [DIVIDEND_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    shifted;
   logic                  fits;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits    = shifted >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? DIVISOR_W'(shifted - {1'b0, dsr_ff}) : DIVISOR_W'(shifted);
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: design/cma_dp.sv
// Datapath: sample store (circular memory), running sum, counters, divider
// and output register. Depends on cma_pkg, cma_div and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "centered_moving_average_top_macros.svh"

module cma_dp #(
   parameter int MAX_RADIUS = cma_pkg::MAX_RADIUS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [cma_pkg::RADIUS_W-1:0]  radius,
   input  wire logic                          cfg_clear,
   input  wire cma_pkg::cmd_type              cmd,
   output cma_pkg::status_type                sts,
   input  wire logic [cma_pkg::SAMPLE_W-1:0]  in_sample,
   input  wire logic                          in_last,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [cma_pkg::SAMPLE_W-1:0]       rsp_mean,
   output logic                               rsp_last
);
   import cma_pkg::*;

   localparam int STORE_DEPTH = 2 * MAX_RADIUS + 1;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int MEM_DEPTH   = 2 ** ADDR_W;
   localparam int RAD_W       = $clog2(MAX_RADIUS + 1);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int SUM_W       = SAMPLE_W + CNT_W;

   logic [SAMPLE_W-1:0] mem [MEM_DEPTH];

   logic [CNT_W-1:0]    seen_ff, seen_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [ADDR_W-1:0]   wp_ff, wp_in;
   logic [RAD_W-1:0]    c_ff, c_in;
   logic [CNT_W-1:0]    top_ff, top_in;
   logic [CNT_W-1:0]    hi_ff, hi_in;
   logic [SAMPLE_W-1:0] sample_ff;
   logic                last_ff;
   logic [SAMPLE_W-1:0] rdata_ff;
   logic                vld_ff, vld_in;
   logic [SAMPLE_W-1:0] mean_ff;
   logic                flag_ff;

   logic [RAD_W-1:0]    eff_r;
   logic [CNT_W-1:0]    r_ext;
   logic [CNT_W-1:0]    full;
   logic [CNT_W-1:0]    hi_cand;
   logic [CNT_W-1:0]    seen_m1;
   logic [RAD_W-1:0]    c_m1;
   logic [ADDR_W-1:0]   rd_addr;
   logic                div_busy;
   logic [SUM_W-1:0]    div_q;
   logic                out_free;
   logic                out_flag;

   assign eff_r   = (32'(radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius);
   assign r_ext   = CNT_W'(eff_r);
   assign full    = CNT_W'({eff_r, 1'b1});
   assign seen_m1 = seen_ff - CNT_W'(1);
   assign c_m1    = c_ff - RAD_W'(1);
   assign hi_cand = CNT_W'(c_m1) + r_ext;
   assign rd_addr = cmd.rd_trim ? (wp_ff - ADDR_W'(top_ff))
                                : (wp_ff - ADDR_W'({eff_r, 1'b0}));
   assign out_free = !vld_ff || rsp_tready;
   assign out_flag = cmd.flush_flag ? (c_ff == '0) : (last_ff && (eff_r == '0));

   always_comb begin
      seen_in = seen_ff;
      sum_in  = sum_ff;
      wp_in   = wp_ff;
      c_in    = c_ff;
      top_in  = top_ff;
      hi_in   = hi_ff;
      priority if (cfg_clear || cmd.clear) begin
         seen_in = '0;
         sum_in  = '0;
      end else if (cmd.sub_evict) begin
         sum_in  = sum_ff - SUM_W'(rdata_ff);
         seen_in = full - CNT_W'(1);
      end else if (cmd.push) begin
         sum_in  = sum_ff + SUM_W'(sample_ff);
         seen_in = seen_ff + CNT_W'(1);
         top_in  = seen_ff;
         wp_in   = wp_ff + ADDR_W'(1);
      end else if (cmd.sub_trim) begin
         sum_in = sum_ff - SUM_W'(rdata_ff);
         top_in = top_ff - CNT_W'(1);
      end else if (cmd.flush_init) begin
         c_in = (r_ext < seen_ff) ? eff_r : RAD_W'(seen_ff);
      end else if (cmd.flush_step) begin
         c_in  = c_m1;
         hi_in = (hi_cand < seen_m1) ? hi_cand : seen_m1;
      end else begin
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (cmd.load_out) begin
         vld_in = 1'b1;
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         sum_ff  <= '0;
         wp_ff   <= '0;
         c_ff    <= '0;
         vld_ff  <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         sum_ff  <= sum_in;
         wp_ff   <= wp_in;
         c_ff    <= c_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      hi_ff  <= hi_in;
      if (cmd.capture) begin
         sample_ff <= in_sample;
         last_ff   <= in_last;
      end
      if (cmd.load_out) begin
         mean_ff <= div_q[SAMPLE_W-1:0];
         flag_ff <= out_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wp_in] <= sample_ff;
      end
      rdata_ff <= mem[rd_addr];
   end

   cma_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (top_ff + CNT_W'(1)),
      .busy     (div_busy),
      .quotient (div_q)
   );

   always_comb begin
      sts.need_evict = seen_ff >= full;
      sts.emit_ok    = seen_ff >= (r_ext + CNT_W'(1));
      sts.last       = last_ff;
      sts.c_zero     = (c_ff == '0);
      sts.trim_more  = top_ff > hi_ff;
      sts.div_busy   = div_busy;
      sts.out_free   = out_free;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_mean   = mean_ff;
   assign rsp_last   = flag_ff;

   `CMA_ASSERT(a_seen_bound, clock, reset, seen_ff <= full, "fill count beyond window")
   `CMA_ASSERT(a_trim_above, clock, reset, cmd.sub_trim |-> (top_ff > hi_ff),
               "trim below window top")
   `CMA_ASSERT(a_divisor_ok, clock, reset, cmd.div_start |-> (top_ff < seen_ff),
               "divisor exceeds samples held")

endmodule

`default_nettype wire

FILE: design/cma_ctrl.sv
// Controller state machine: sequences store update, divide, output and the
// end-of-record flush. Depends on cma_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "centered_moving_average_top_macros.svh"

module cma_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output cma_pkg::cmd_type          cmd,
   input  wire cma_pkg::status_type  sts
);
   import cma_pkg::*;

   typedef enum logic [14:0] {
      ST_IDLE       = 15'b000000000000001,
      ST_EVICT_RD   = 15'b000000000000010,
      ST_EVICT_SUB  = 15'b000000000000100,
      ST_PUSH       = 15'b000000000001000,
      ST_CHECK      = 15'b000000000010000,
      ST_DIV        = 15'b000000000100000,
      ST_EMIT       = 15'b000000001000000,
      ST_FLUSH_INIT = 15'b000000010000000,
      ST_FLUSH_CHK  = 15'b000000100000000,
      ST_FLUSH_STEP = 15'b000001000000000,
      ST_TRIM_CMP   = 15'b000010000000000,
      ST_TRIM_RD    = 15'b000100000000000,
      ST_TRIM_SUB   = 15'b001000000000000,
      ST_FLUSH_DIV  = 15'b010000000000000,
      ST_FLUSH_EMIT = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = sts.need_evict ? ST_EVICT_RD : ST_PUSH;
            end
         end
         ST_EVICT_RD: begin
            state_in = ST_EVICT_SUB;
         end
         ST_EVICT_SUB: begin
            cmd.sub_evict = 1'b1;
            state_in      = ST_PUSH;
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.emit_ok) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else if (sts.last) begin
               state_in = ST_FLUSH_INIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (!sts.div_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = sts.last ? ST_FLUSH_INIT : ST_IDLE;
            end
         end
         ST_FLUSH_INIT: begin
            cmd.flush_init = 1'b1;
            state_in       = ST_FLUSH_CHK;
         end
         ST_FLUSH_CHK: begin
            if (sts.c_zero) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_FLUSH_STEP;
            end
         end
         ST_FLUSH_STEP: begin
            cmd.flush_step = 1'b1;
            state_in       = ST_TRIM_CMP;
         end
         ST_TRIM_CMP: begin
            if (sts.trim_more) begin
               state_in = ST_TRIM_RD;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_FLUSH_DIV;
            end
         end
         ST_TRIM_RD: begin
            cmd.rd_trim = 1'b1;
            state_in    = ST_TRIM_SUB;
         end
         ST_TRIM_SUB: begin
            cmd.sub_trim = 1'b1;
            state_in     = ST_TRIM_CMP;
         end
         ST_FLUSH_DIV: begin
            if (!sts.div_busy) begin
               state_in = ST_FLUSH_EMIT;
            end
         end
         ST_FLUSH_EMIT: begin
            if (sts.out_free) begin
               cmd.load_out   = 1'b1;
               cmd.flush_flag = 1'b1;
               state_in       = ST_FLUSH_CHK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `CMA_ASSERT(a_load_free, clock, reset, cmd.load_out |-> sts.out_free,
               "output loaded while occupied")
   `CMA_ASSERT(a_div_idle, clock, reset, cmd.div_start |-> !sts.div_busy,
               "divide started while busy")
   `CMA_ASSERT(a_clear_done, clock, reset, cmd.clear |-> sts.c_zero,
               "record cleared before flush done")

endmodule

`default_nettype wire

FILE: sim/centered_moving_average_top_tb.sv
// Self-checking testbench for centered_moving_average_top: directed table, then random
// records under several radius settings and handshake idle patterns, checked by a predictor.
// Depends on cma_pkg and the centered moving average RTL.
`timescale 1ns / 1ps

module centered_moving_average_top_tb;
   import cma_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] RADIUS_ADDR   = {REG_RADIUS, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR = {~REG_RADIUS, 2'b00};
   localparam int STORE_DEPTH    = 2 * MAX_RADIUS_DEF + 1;
   localparam int SETTLE_CYCLES  = 64;
   localparam int LONG_HOLD      = 600;
   localparam int HOLD_PHASE     = 4;
   localparam int PHASES         = 8;
   localparam int PHASE_REQUESTS = 40;
   localparam int DIRECTED_ROWS  = 23;

   typedef enum logic {ROW_SAMPLE, ROW_CSR_WRITE} row_kind_type;

   typedef struct packed {
      logic [7:0] mean;
      logic       last;
   } mean_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_ADDR_W-1:0] addr;
      logic [7:0]            value;
      logic                  last;
      logic                  typed;
      logic [7:0]            want_mean;
      logic                  want_last;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] sample
   logic                  req_tlast;   // last_sample
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;   // [7:0] mean_sample
   logic                  rsp_tlast;   // last_mean
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   centered_moving_average_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   logic [7:0]  sample_hist [STORE_DEPTH];
   int unsigned hist_sum;
   int unsigned hist_fill;
   logic [4:0]  cur_radius;

   mean_type expected_means[$];
   int       mismatch_count;
   int       req_idle_pct;
   int       rsp_stall_pct;
   bit       long_hold_req;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_SAMPLE,    RADIUS_ADDR,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE,    RADIUS_ADDR,   8'd255, 1'b0, 1'b1, 8'd127, 1'b0},
      '{ROW_SAMPLE,    RADIUS_ADDR,   8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
      '{ROW_CSR_WRITE, RADIUS_ADDR,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE,    RADIUS_ADDR,   8'd255, 1'b0, 1'b1, 8'd255, 1'b0},
      '{ROW_SAMPLE,    RADIUS_ADDR,   8'd0,   1'b1, 1'b1, 8'd0,   1'b1},
      '{ROW_CSR_WRITE, RADIUS_ADDR,   8'd31,  1'b0, 1'b0, 8'd0,   1'b0},
      // short record at the widest radius
      '{ROW_SAMPLE,    RADIUS_ADDR,   8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE,    RADIUS_ADDR,   8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE,    RADIUS_ADDR,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE,    RADIUS_ADDR,   8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
      // partial record, dropped by the radius write
      '{ROW_SAMPLE,    RADIUS_ADDR,   8'd10,  1'b0, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE,    RADIUS_ADDR,   8'd20,  1'b0, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE,    RADIUS_ADDR,   8'd30,  1'b0, 1'b0, 8'd0,   1'b0},
      '{ROW_CSR_WRITE, RADIUS_ADDR,   8'd2,   1'b0, 1'b0, 8'd0,   1'b0},
      '{ROW_CSR_WRITE, UNMAPPED_ADDR, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE,    RADIUS_ADDR,   8'd77,  1'b1, 1'b1, 8'd77,  1'b1},
      '{ROW_SAMPLE,    RADIUS_ADDR,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE,    RADIUS_ADDR,   8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE,    RADIUS_ADDR,   8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE,    RADIUS_ADDR,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE,    RADIUS_ADDR,   8'd128, 1'b0, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE,    RADIUS_ADDR,   8'd255, 1'b1, 1'b0, 8'd0,   1'b0}
   };

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic void clear_record();
      foreach (sample_hist[k]) sample_hist[k] = 8'd0;
      hist_sum  = 0;
      hist_fill = 0;
   endfunction

   function automatic void predict_means(input logic [7:0] s, input logic l,
                                         output mean_type got[$]);
      int unsigned r;
      int unsigned full;
      int unsigned c;
      int unsigned hi;
      int unsigned part;
      mean_type m;
      got  = {};
      r    = cur_radius;
      full = 2 * r + 1;
      if (hist_fill >= full) begin
         hist_sum  -= sample_hist[full-1];
         hist_fill  = full - 1;
      end
      for (int k = STORE_DEPTH - 1; k > 0; k--) sample_hist[k] = sample_hist[k-1];
      sample_hist[0] = s;
      hist_sum += s;
      hist_fill++;
      if (hist_fill >= r + 1) begin
         m.mean = 8'(hist_sum / hist_fill);
         m.last = l && (r == 0);
         got.push_back(m);
      end
      if (l) begin
         c = (r < hist_fill) ? r : hist_fill;
         // leftover centres, oldest first
         while (c > 0) begin
            c--;
            hi = (c + r > hist_fill - 1) ? hist_fill - 1 : c + r;
            part = 0;
            for (int k = 0; k <= hi; k++) part += sample_hist[k];
            m.mean = 8'(part / (hi + 1));
            m.last = (c == 0);
            got.push_back(m);
         end
         clear_record();
      end
   endfunction

   task automatic send_sample(input logic [7:0] s, input logic l, input logic typed,
                              input mean_type want);
      mean_type got[$];
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_means(s, l, got);
      if (typed) expected_means.push_back(want);
      else foreach (got[k]) expected_means.push_back(got[k]);
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      if (wr && addr[CSR_ADDR_W-1:2] == REG_RADIUS) begin
         cur_radius = wdata[RADIUS_W-1:0];
         clear_record();
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_radius(input logic [CSR_ADDR_W-1:0] addr, input int unsigned value);
      logic [CSR_DATA_W-1:0] rdata;
      wait_for_idle();
      csr_access(1'b1, addr, CSR_DATA_W'(value), rdata);
      csr_access(1'b0, RADIUS_ADDR, '0, rdata);
      if (rdata !== CSR_DATA_W'(cur_radius))
         report_mismatch($sformatf("radius readback %0h, want %0d", rdata, cur_radius));
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int unsigned hold_left;
      bit          hold_started;
      hold_left    = 0;
      hold_started = 1'b0;
      rsp_tready   = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !hold_started) begin
            hold_started = 1'b1;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      mean_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_means.size() == 0) begin
            report_mismatch($sformatf("unexpected mean %0d last %0b", rsp_tdata, rsp_tlast));
         end else begin
            want = expected_means.pop_front();
            if (rsp_tdata !== want.mean)
               report_mismatch($sformatf("mean %0d, want %0d", rsp_tdata, want.mean));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last %0b, want %0b", rsp_tlast, want.last));
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int          fixed_radius [PHASES];
      int          idle_pct     [4];
      int          stall_pct    [4];
      int unsigned r;
      int unsigned sent;
      int unsigned rec_len;
      logic [7:0]  s;
      fixed_radius   = '{1, 0, 31, -1, 2, -1, 31, -1};
      idle_pct       = '{0, 51, 0, 17};
      stall_pct      = '{0, 0, 51, 17};
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      mismatch_count = 0;
      req_idle_pct   = 0;
      rsp_stall_pct  = 0;
      long_hold_req  = 1'b0;
      cur_radius     = RADIUS_RESET;
      clear_record();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR_WRITE)
            set_radius(directed_rows[i].addr, directed_rows[i].value);
         else
            send_sample(directed_rows[i].value, directed_rows[i].last, directed_rows[i].typed,
                        '{mean: directed_rows[i].want_mean, last: directed_rows[i].want_last});
      end

      for (int p = 0; p < PHASES; p++) begin
         r = (fixed_radius[p] < 0) ? $urandom_range(31) : fixed_radius[p];
         set_radius(RADIUS_ADDR, r);
         req_idle_pct  = idle_pct[p % 4];
         rsp_stall_pct = stall_pct[p % 4];
         if (p == HOLD_PHASE) long_hold_req = 1'b1;
         sent = 0;
         while (sent < PHASE_REQUESTS) begin
            if ($urandom_range(3) == 0) rec_len = $urandom_range(r + 1, 1);
            else rec_len = $urandom_range(3 * r + 4, r + 1);
            // a record cut off at the phase end is dropped by the next radius write
            for (int k = 0; k < rec_len && sent < PHASE_REQUESTS; k++) begin
               case ($urandom_range(7))
                  0:       s = 8'd0;
                  1:       s = 8'd255;
                  default: s = 8'($urandom_range(255));
               endcase
               send_sample(s, k == rec_len - 1, 1'b0, '0);
               sent++;
            end
         end
      end

      wait_for_idle();
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
